@@ src/sskth_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted store k-th select package
// Shared types, codes and sizes for the sorted store and its cells.
// ----------------------------------------------------------------------------
package sskth_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int RANK_W   = 12;
    localparam int VALUE_W  = 32;
    localparam int OUT_CNT_W = 7;

    localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_SMALLEST = 2'd1,
        FUNC_LARGEST  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]         rank;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [1:0]                status;
        logic [OUT_CNT_W-1:0]      stored_count;
    } rsp_t;

    typedef struct packed {
        logic insert;
        logic occupied;
        logic at_tail;
    } cell_ctrl_t;

endpackage

@@ src/sskth_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted store cell
// Holds one entry; on insert takes the neighbor's entry, the new value, or holds.
// ----------------------------------------------------------------------------
module sskth_cell (
    input  logic                                  clk,
    input  sskth_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [sskth_pkg::VALUE_W-1:0]  new_value,
    input  logic signed [sskth_pkg::VALUE_W-1:0]  prev_value,
    input  logic                                  prev_shift,
    output logic signed [sskth_pkg::VALUE_W-1:0]  value,
    output logic                                  shift
);
    import sskth_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    assign shift = ctrl.occupied && (value_reg > new_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (prev_shift)
            begin
                value_next = prev_value;
            end
            else if (shift || ctrl.at_tail)
            begin
                value_next = new_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ src/sskth_array.sv @@
// ----------------------------------------------------------------------------
// Sorted store cell chain
// Row of compare-and-shift cells with a rank-indexed read port.
// ----------------------------------------------------------------------------
module sskth_array (
    input  logic                                  clk,
    input  logic                                  insert,
    input  logic signed [sskth_pkg::VALUE_W-1:0]  new_value,
    input  logic [sskth_pkg::CNT_W-1:0]           count,
    input  logic [sskth_pkg::IDX_W-1:0]           rd_idx,
    output logic signed [sskth_pkg::VALUE_W-1:0]  rd_value
);
    import sskth_pkg::*;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      cell_shift [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_ctrl_t                ctrl;
        logic signed [VALUE_W-1:0] prev_value;
        logic                      prev_shift;

        assign ctrl.insert   = insert;
        assign ctrl.occupied = CNT_W'(i) < count;
        assign ctrl.at_tail  = CNT_W'(i) == count;

        if (i == 0)
        begin : g_head
            assign prev_value = '0;
            assign prev_shift = 1'b0;
        end
        else
        begin : g_body
            assign prev_value = cell_value[i-1];
            assign prev_shift = cell_shift[i-1];
        end

        sskth_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_value  (new_value),
            .prev_value (prev_value),
            .prev_shift (prev_shift),
            .value      (cell_value[i]),
            .shift      (cell_shift[i])
        );
    end

    assign rd_value = cell_value[rd_idx];

endmodule

@@ src/sorted_store_kth_select.sv @@
// A request is captured in the request registers and the state moves to EXEC; the response is
// registered when EXEC finishes, and an insert updates the cell row on that same edge. Requests
// are stalled while in EXEC, and a stalled response holds the next request off.
// Reset empties the store (count to zero) and drops any pending response; entry values
// are left as they were and are never read until written.
// ----------------------------------------------------------------------------
// Sorted store k-th select
// Ascending multiset of signed values with insert and k-th smallest/largest query.
// ----------------------------------------------------------------------------
module sorted_store_kth_select (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sskth_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sskth_pkg::rsp_t   rsp
);
    import sskth_pkg::*;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    rsp_t                      rsp_reg;
    rsp_t                      rsp_next;

    logic [1:0]                func_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      found_reg;
    logic [IDX_W-1:0]          idx_reg;

    logic                      accept;
    logic                      finish;
    logic                      is_query;
    logic                      found;
    logic [RANK_W:0]           rank_ext;
    logic [RANK_W:0]           count_ext;
    logic [RANK_W:0]           idx_small;
    logic [RANK_W:0]           idx_large;
    logic                      full;
    logic                      do_insert;
    logic signed [VALUE_W-1:0] rd_value;

    assign accept    = req_valid && !req_stall;
    assign finish    = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign full      = count_reg == CNT_W'(CAPACITY);
    assign do_insert = finish && (func_reg == FUNC_INSERT) && !full;

    assign rank_ext  = {1'b0, req.rank};
    assign count_ext = (RANK_W+1)'(count_reg);
    assign is_query  = (req.func == FUNC_SMALLEST) || (req.func == FUNC_LARGEST);
    assign found     = is_query && (req.rank != '0) && (rank_ext <= count_ext);
    assign idx_small = rank_ext - (RANK_W+1)'(1);
    assign idx_large = count_ext - rank_ext;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:  req_stall = 1'b0;
            S_EXEC:  req_stall = 1'b1;
            default: req_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (finish)
        begin
            rsp_valid_next = 1'b1;
            if (func_reg == FUNC_INSERT)
            begin
                rsp_next.result_value = '0;
                rsp_next.status       = full ? ST_FULL : ST_OK;
            end
            else if (found_reg)
            begin
                rsp_next.result_value = rd_value;
                rsp_next.status       = ST_OK;
            end
            else
            begin
                rsp_next.result_value = INT_MIN;
                rsp_next.status       = ST_NOT_FOUND;
            end
            rsp_next.stored_count = OUT_CNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            func_reg  <= req.func;
            value_reg <= req.value;
            found_reg <= found;
            idx_reg   <= (req.func == FUNC_SMALLEST) ? idx_small[IDX_W-1:0]
                                                     : idx_large[IDX_W-1:0];
        end
    end

    sskth_array u_array (
        .clk       (clk),
        .insert    (do_insert),
        .new_value (value_reg),
        .count     (count_reg),
        .rd_idx    (idx_reg),
        .rd_value  (rd_value)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ tb/sv/sorted_store_kth_select_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted store k-th select testbench
// Sends insert and k-th smallest/largest requests through the valid/stall
// handshake, predicts every response with a software copy of the ascending
// store, and checks each response field by field under varied idling,
// stalling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module sorted_store_kth_select_tb;

    import sskth_pkg::*;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         HOLD_OFF_LEN   = 400;
    localparam int         PHASE_ITEMS    = 112;

    class kth_select_scoreboard;
        logic signed [VALUE_W-1:0] held_values[$];
        rsp_t                      expected_rsps[$];
        int                        errors = 0;

        function void note_request(req_t r);
            rsp_t                      p;
            logic signed [VALUE_W-1:0] v;
            int                        k;
            int                        pos;
            v = r.value;
            k = r.rank;
            p.result_value = INT_MIN;
            p.status = ST_NOT_FOUND;
            case (r.func)
                FUNC_INSERT:
                begin
                    p.result_value = '0;
                    if (held_values.size() >= CAPACITY)
                        p.status = ST_FULL;
                    else
                    begin
                        pos = 0;
                        while (pos < held_values.size() && held_values[pos] <= v)
                            pos++;
                        held_values.insert(pos, v);
                        p.status = ST_OK;
                    end
                end
                FUNC_SMALLEST, FUNC_LARGEST:
                begin
                    if (k != 0 && k <= held_values.size())
                    begin
                        if (r.func == FUNC_SMALLEST)
                            p.result_value = held_values[k - 1];
                        else
                            p.result_value = held_values[held_values.size() - k];
                        p.status = ST_OK;
                    end
                end
                default:
                begin
                end
            endcase
            p.stored_count = OUT_CNT_W'(held_values.size());
            expected_rsps.insert(expected_rsps.size(), p);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response: value %0d status %0d count %0d",
                         $time, got.result_value, got.status, got.stored_count);
                return;
            end
            want = expected_rsps.pop_front();
            if (got.result_value !== want.result_value || got.status !== want.status ||
                got.stored_count !== want.stored_count)
            begin
                errors++;
                $display("%0t: mismatch: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                         $time, want.result_value, want.status, want.stored_count,
                         got.result_value, got.status, got.stored_count);
            end
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    kth_select_scoreboard sb = new;

    bit sender_idles;
    bit receiver_stalls;
    bit hold_off_request;
    int idle_pct;
    int planned_count;
    int quiet_cycles;

    sorted_store_kth_select dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if (req_valid && !req_stall)
                sb.note_request(req);
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                hold_off_request = 1'b0;
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= receiver_stalls && ($urandom_range(99) < idle_pct);
        end
    end

    function automatic req_t make_request(logic [1:0] f, logic signed [VALUE_W-1:0] v,
                                          logic [RANK_W-1:0] k);
        req_t r;
        r.func = f;
        r.value = v;
        r.rank = k;
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int d;
        d = $urandom_range(16);
        case ($urandom_range(3))
            0, 1: return $urandom;
            2: return d - 8;
            default:
                if ($urandom_range(1))
                    return INT_MIN + d[1:0];
                else
                    return 32'sh7fffffff - d[1:0];
        endcase
    endfunction

    function automatic req_t random_request();
        int         roll;
        int         k;
        logic [1:0] f;
        roll = $urandom_range(99);
        if (roll < 3)
            f = FUNC_UNUSED;
        else if (roll < ((planned_count < CAPACITY) ? 48 : 23))
            f = FUNC_INSERT;
        else if ($urandom_range(1))
            f = FUNC_SMALLEST;
        else
            f = FUNC_LARGEST;
        if (f == FUNC_INSERT)
            return make_request(f, pick_value(), RANK_W'($urandom_range(4095)));
        case ($urandom_range(9))
            0: k = 0;
            1: k = planned_count + 1;
            2: k = $urandom_range(4095);
            default: k = (planned_count == 0) ? $urandom_range(3)
                                              : $urandom_range(planned_count, 1);
        endcase
        return make_request(f, $urandom, RANK_W'(k));
    endfunction

    task automatic send_request(input req_t r);
        if (sender_idles && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (req_stall);
        if (r.func == FUNC_INSERT && planned_count < CAPACITY)
            planned_count++;
    endtask

    task automatic issue(input logic [1:0] f, input logic signed [VALUE_W-1:0] v,
                         input logic [RANK_W-1:0] k);
        send_request(make_request(f, v, k));
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        hold_off_request = 1'b0;
        idle_pct = 0;
        planned_count = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(FUNC_SMALLEST, 0, 1);
        issue(FUNC_LARGEST, 0, 1);
        issue(FUNC_UNUSED, -1, 4095);
        issue(FUNC_INSERT, 0, 4095);
        issue(FUNC_INSERT, INT_MIN, 0);
        issue(FUNC_INSERT, 32'sh7fffffff, 0);
        issue(FUNC_INSERT, -1, 0);
        issue(FUNC_INSERT, 5, 0);
        issue(FUNC_INSERT, 5, 0);
        issue(FUNC_INSERT, -1, 0);
        issue(FUNC_SMALLEST, 0, 1);
        issue(FUNC_LARGEST, 0, 1);
        issue(FUNC_SMALLEST, 0, 7);
        issue(FUNC_LARGEST, 0, 7);
        issue(FUNC_SMALLEST, 0, 8);
        issue(FUNC_LARGEST, 0, 8);
        issue(FUNC_SMALLEST, 0, 0);
        issue(FUNC_LARGEST, -1, 0);
        issue(FUNC_SMALLEST, 32'sh7fffffff, 4095);
        issue(FUNC_SMALLEST, 0, 4);
        issue(FUNC_LARGEST, 0, 3);
        issue(FUNC_UNUSED, 0, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idles = (phase == 1) || (phase == 3);
            receiver_stalls = (phase == 2) || (phase == 3);
            idle_pct = (phase == 3) ? 24 : 77;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // fill the block and stall its input while the sender keeps offering
                if (phase == 0 && i == 40)
                    hold_off_request = 1'b1;
                send_request(random_request());
            end
        end

        req_valid <= 1'b0;
        receiver_stalls = 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d responses never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
